// File: hdl/drhm_pkg.sv
// Shared types, codes and constants of the drop-rate health monitor.
// No dependencies; every other file of the monitor uses this package.
`timescale 1ns / 1ps

package drhm_pkg;

  localparam int CNT_W        = 64;
  localparam int FRAC_W       = 17;
  localparam int CHECK_PERIOD = 1000;
  localparam int PHASE_W      = 10;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int PADDR_W      = 4;

  localparam logic [FRAC_W-1:0] FRACTION_ONE = FRAC_W'(65536);
  localparam logic [FRAC_W-1:0] DEG_FRAC_RST = FRAC_W'(3277);
  localparam logic [FRAC_W-1:0] ERR_FRAC_RST = FRAC_W'(9830);

  typedef enum logic [2:0] {
    KIND_PROCESSED = 3'd0,
    KIND_DROPPED   = 3'd1,
    KIND_SIGNAL    = 3'd2,
    KIND_ERROR     = 3'd3,
    KIND_DEGRADED  = 3'd4,
    KIND_HEALTHY   = 3'd5,
    KIND_CLEAR     = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ADD_PROC,
    OP_ADD_DROP,
    OP_DROP_CHECK,
    OP_SIGNAL,
    OP_ERROR,
    OP_DEGRADED,
    OP_HEALTHY,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    HEALTH_OK       = 2'd0,
    HEALTH_DEGRADED = 2'd1,
    HEALTH_ERROR    = 2'd2
  } health_t;

  typedef enum logic [1:0] {
    REG_ENABLE   = 2'd0,
    REG_DEG_FRAC = 2'd1,
    REG_ERR_FRAC = 2'd2
  } reg_idx_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] count;
  } item_t;

  function automatic logic [FRAC_W-1:0] clamp_frac(input logic [FRAC_W-1:0] f);
    clamp_frac = (f > FRACTION_ONE) ? FRACTION_ONE : f;
  endfunction

endpackage

// File: hdl/drhm_front.sv
// Front end: accepts events, classifies them into operations and keeps the
// drop-check phase counter. Depends on drhm_pkg.
`timescale 1ns / 1ps

module drhm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [2:0]                  in_kind,
  input  logic [drhm_pkg::CNT_W-1:0]  in_count,
  output logic                        in_stall,
  input  logic                        enable,
  input  logic                        q_full,
  output logic                        push,
  output drhm_pkg::item_t             item
);

  logic [drhm_pkg::PHASE_W-1:0] phase_r;
  logic [drhm_pkg::PHASE_W-1:0] phase_nxt;
  logic [drhm_pkg::PHASE_W:0]   phase_inc;
  logic                         count_nz;

  always_comb begin
    in_stall   = q_full;
    push       = in_valid && !q_full;
    item.count = in_count;
    item.op    = drhm_pkg::OP_NOP;
    phase_inc  = {1'b0, phase_r} + (drhm_pkg::PHASE_W + 1)'(1);
    count_nz   = (in_count != '0);
    phase_nxt  = phase_r;
    unique case (drhm_pkg::kind_t'(in_kind))
      drhm_pkg::KIND_PROCESSED: begin
        if (enable && count_nz) begin
          item.op = drhm_pkg::OP_ADD_PROC;
        end
      end
      drhm_pkg::KIND_DROPPED: begin
        if (enable && count_nz) begin
          if (phase_inc >= (drhm_pkg::PHASE_W + 1)'(drhm_pkg::CHECK_PERIOD)) begin
            item.op = drhm_pkg::OP_DROP_CHECK;
            if (push) begin
              phase_nxt = '0;
            end
          end else begin
            item.op = drhm_pkg::OP_ADD_DROP;
            if (push) begin
              phase_nxt = phase_inc[drhm_pkg::PHASE_W-1:0];
            end
          end
        end
      end
      drhm_pkg::KIND_SIGNAL: begin
        if (enable) begin
          item.op = drhm_pkg::OP_SIGNAL;
        end
      end
      drhm_pkg::KIND_ERROR:    item.op = drhm_pkg::OP_ERROR;
      drhm_pkg::KIND_DEGRADED: item.op = drhm_pkg::OP_DEGRADED;
      drhm_pkg::KIND_HEALTHY:  item.op = drhm_pkg::OP_HEALTHY;
      drhm_pkg::KIND_CLEAR:    item.op = drhm_pkg::OP_CLEAR;
      default:                 item.op = drhm_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

// File: hdl/drhm_queue.sv
// Short queue of classified operations between the front and back ends.
// Depends on drhm_pkg.
`timescale 1ns / 1ps

module drhm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  drhm_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output drhm_pkg::item_t q_item
);

  drhm_pkg::item_t              mem_r [drhm_pkg::QUEUE_DEPTH];
  logic [drhm_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [drhm_pkg::QPTR_W-1:0]  wr_ptr_nxt;
  logic [drhm_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [drhm_pkg::QPTR_W-1:0]  rd_ptr_nxt;
  logic [drhm_pkg::QPTR_W:0]    cnt_r;
  logic [drhm_pkg::QPTR_W:0]    cnt_nxt;
  logic                         do_pop;

  always_comb begin
    full       = (cnt_r == (drhm_pkg::QPTR_W + 1)'(drhm_pkg::QUEUE_DEPTH));
    q_valid    = (cnt_r != '0);
    q_item     = mem_r[rd_ptr_r];
    do_pop     = pop && q_valid;
    wr_ptr_nxt = push ? wr_ptr_r + drhm_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + drhm_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + (drhm_pkg::QPTR_W + 1)'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - (drhm_pkg::QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: hdl/drhm_back.sv
// Back end: saturating counters, health state, the two-step drop-ratio check
// and the output register. Depends on drhm_pkg.
`timescale 1ns / 1ps

module drhm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  drhm_pkg::item_t               q_item,
  output logic                          pop,
  input  logic [drhm_pkg::FRAC_W-1:0]   thr_deg,
  input  logic [drhm_pkg::FRAC_W-1:0]   thr_err,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_health,
  output logic [drhm_pkg::CNT_W-1:0]    out_processed_total,
  output logic [drhm_pkg::CNT_W-1:0]    out_dropped_total,
  output logic [drhm_pkg::CNT_W-1:0]    out_signal_total,
  output logic [drhm_pkg::CNT_W-1:0]    out_error_total
);

  localparam int CW = drhm_pkg::CNT_W;
  localparam int FW = drhm_pkg::FRAC_W;
  localparam int HW = CW / 2;
  localparam int PW = HW + FW;
  localparam int SW = CW + FW;

  typedef enum logic [1:0] {
    ST_EXEC,
    ST_MUL,
    ST_CMP
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     proc_r, proc_nxt;
  logic [CW-1:0]     drop_r, drop_nxt;
  logic [CW-1:0]     sig_r, sig_nxt;
  logic [CW-1:0]     err_r, err_nxt;
  drhm_pkg::health_t health_r, health_nxt;

  logic [PW-1:0]     pp_e_lo_r, pp_e_lo_nxt;
  logic [PW-1:0]     pp_e_hi_r, pp_e_hi_nxt;
  logic [PW-1:0]     pp_d_lo_r, pp_d_lo_nxt;
  logic [PW-1:0]     pp_d_hi_r, pp_d_hi_nxt;
  logic              proc_zero_r, proc_zero_nxt;

  logic              out_valid_r, out_valid_nxt;
  drhm_pkg::health_t out_health_r, out_health_nxt;
  logic [CW-1:0]     out_proc_r, out_proc_nxt;
  logic [CW-1:0]     out_drop_r, out_drop_nxt;
  logic [CW-1:0]     out_sig_r, out_sig_nxt;
  logic [CW-1:0]     out_err_r, out_err_nxt;

  logic              out_free;
  logic [CW:0]       add_sum;
  logic [CW-1:0]     add_a;
  logic [CW-1:0]     add_b;
  logic [CW-1:0]     add_sat;
  logic [SW-1:0]     lhs;
  logic [SW-1:0]     rhs_e;
  logic [SW-1:0]     rhs_d;
  logic              ge_e;
  logic              ge_d;

  always_comb begin
    add_a = proc_r;
    add_b = q_item.count;
    unique case (q_item.op) inside
      drhm_pkg::OP_ADD_DROP, drhm_pkg::OP_DROP_CHECK: add_a = drop_r;
      drhm_pkg::OP_SIGNAL: begin
        add_a = sig_r;
        add_b = CW'(1);
      end
      drhm_pkg::OP_ERROR: begin
        add_a = err_r;
        add_b = CW'(1);
      end
      default: add_a = proc_r;
    endcase
    add_sum = {1'b0, add_a} + {1'b0, add_b};
    add_sat = add_sum[CW] ? {CW{1'b1}} : add_sum[CW-1:0];

    lhs   = {1'b0, drop_r, 16'b0};
    rhs_e = {{(SW - PW){1'b0}}, pp_e_lo_r} + {pp_e_hi_r, {HW{1'b0}}};
    rhs_d = {{(SW - PW){1'b0}}, pp_d_lo_r} + {pp_d_hi_r, {HW{1'b0}}};
    ge_e  = proc_zero_r ? (thr_err == '0) : (lhs >= rhs_e);
    ge_d  = proc_zero_r ? (thr_deg == '0) : (lhs >= rhs_d);
  end

  always_comb begin
    state_nxt      = state_r;
    proc_nxt       = proc_r;
    drop_nxt       = drop_r;
    sig_nxt        = sig_r;
    err_nxt        = err_r;
    health_nxt     = health_r;
    pp_e_lo_nxt    = pp_e_lo_r;
    pp_e_hi_nxt    = pp_e_hi_r;
    pp_d_lo_nxt    = pp_d_lo_r;
    pp_d_hi_nxt    = pp_d_hi_r;
    proc_zero_nxt  = proc_zero_r;
    out_valid_nxt  = out_valid_r;
    out_health_nxt = out_health_r;
    out_proc_nxt   = out_proc_r;
    out_drop_nxt   = out_drop_r;
    out_sig_nxt    = out_sig_r;
    out_err_nxt    = out_err_r;
    pop            = 1'b0;
    out_free       = !out_valid_r || !out_stall;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_EXEC: begin
        if (q_valid && out_free) begin
          pop = 1'b1;
          unique case (q_item.op)
            drhm_pkg::OP_ADD_PROC:   proc_nxt = add_sat;
            drhm_pkg::OP_ADD_DROP:   drop_nxt = add_sat;
            drhm_pkg::OP_DROP_CHECK: drop_nxt = add_sat;
            drhm_pkg::OP_SIGNAL:     sig_nxt  = add_sat;
            drhm_pkg::OP_ERROR: begin
              err_nxt    = add_sat;
              health_nxt = drhm_pkg::HEALTH_ERROR;
            end
            drhm_pkg::OP_DEGRADED: health_nxt = drhm_pkg::HEALTH_DEGRADED;
            drhm_pkg::OP_HEALTHY: begin
              err_nxt    = '0;
              health_nxt = drhm_pkg::HEALTH_OK;
            end
            drhm_pkg::OP_CLEAR: begin
              proc_nxt   = '0;
              drop_nxt   = '0;
              sig_nxt    = '0;
              err_nxt    = '0;
              health_nxt = drhm_pkg::HEALTH_OK;
            end
            default: health_nxt = health_r;
          endcase
          if (q_item.op == drhm_pkg::OP_DROP_CHECK) begin
            state_nxt = ST_MUL;
          end else begin
            out_valid_nxt  = 1'b1;
            out_health_nxt = health_nxt;
            out_proc_nxt   = proc_nxt;
            out_drop_nxt   = drop_nxt;
            out_sig_nxt    = sig_nxt;
            out_err_nxt    = err_nxt;
          end
        end
      end
      ST_MUL: begin
        pp_e_lo_nxt   = PW'(proc_r[HW-1:0]) * PW'(thr_err);
        pp_e_hi_nxt   = PW'(proc_r[CW-1:HW]) * PW'(thr_err);
        pp_d_lo_nxt   = PW'(proc_r[HW-1:0]) * PW'(thr_deg);
        pp_d_hi_nxt   = PW'(proc_r[CW-1:HW]) * PW'(thr_deg);
        proc_zero_nxt = (proc_r == '0);
        state_nxt     = ST_CMP;
      end
      ST_CMP: begin
        if (out_free) begin
          if (ge_e) begin
            health_nxt = drhm_pkg::HEALTH_ERROR;
          end else if (ge_d) begin
            health_nxt = drhm_pkg::HEALTH_DEGRADED;
          end else begin
            health_nxt = drhm_pkg::HEALTH_OK;
          end
          out_valid_nxt  = 1'b1;
          out_health_nxt = health_nxt;
          out_proc_nxt   = proc_r;
          out_drop_nxt   = drop_r;
          out_sig_nxt    = sig_r;
          out_err_nxt    = err_r;
          state_nxt      = ST_EXEC;
        end
      end
      default: state_nxt = ST_EXEC;
    endcase
  end

  always_ff @(posedge clk) begin
    pp_e_lo_r    <= pp_e_lo_nxt;
    pp_e_hi_r    <= pp_e_hi_nxt;
    pp_d_lo_r    <= pp_d_lo_nxt;
    pp_d_hi_r    <= pp_d_hi_nxt;
    proc_zero_r  <= proc_zero_nxt;
    out_health_r <= out_health_nxt;
    out_proc_r   <= out_proc_nxt;
    out_drop_r   <= out_drop_nxt;
    out_sig_r    <= out_sig_nxt;
    out_err_r    <= out_err_nxt;
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      proc_r      <= '0;
      drop_r      <= '0;
      sig_r       <= '0;
      err_r       <= '0;
      health_r    <= drhm_pkg::HEALTH_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      proc_r      <= proc_nxt;
      drop_r      <= drop_nxt;
      sig_r       <= sig_nxt;
      err_r       <= err_nxt;
      health_r    <= health_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_health          = out_health_r;
  assign out_processed_total = out_proc_r;
  assign out_dropped_total   = out_drop_r;
  assign out_signal_total    = out_sig_r;
  assign out_error_total     = out_err_r;

`ifndef SYNTHESIS
  a_mul_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |=> state_r == ST_CMP)
    else $error("drop check skipped its compare step");

  a_check_enters_mul: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_item.op == drhm_pkg::OP_DROP_CHECK |=> state_r == ST_MUL && $stable(out_valid_r)
      || state_r == ST_MUL && $fell(out_valid_r))
    else $error("drop check item produced a result before its compare");

  a_no_pop_in_check: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_EXEC |-> !pop)
    else $error("queue popped while a drop check is in progress");

  a_out_health_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_health_r != 2'd3)
    else $error("result carries an undefined health code");

  a_counters_cleared: assert property (@(posedge clk)
    !rst_n |=> proc_r == '0 && drop_r == '0 && sig_r == '0 && err_r == '0)
    else $error("counters not cleared by reset");
`endif

endmodule

// File: hdl/drop_rate_health_monitor.sv
// An accepted item passes through the queue into the output register and raises
// out_valid; a drop event that runs the ratio check first takes the multiply and
// compare steps. Throughput: one item per cycle while the queue and out_stall
// allow; a ratio-checking drop event (one in every 1000) holds pops until compare.
// Reset (synchronous, rst_n low) zeroes the counters and check phase, sets
// health to ok, empties the queue and restores the register defaults.
`timescale 1ns / 1ps

module drop_rate_health_monitor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_kind,
  input  logic [drhm_pkg::CNT_W-1:0]    in_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_health,
  output logic [drhm_pkg::CNT_W-1:0]    out_processed_total,
  output logic [drhm_pkg::CNT_W-1:0]    out_dropped_total,
  output logic [drhm_pkg::CNT_W-1:0]    out_signal_total,
  output logic [drhm_pkg::CNT_W-1:0]    out_error_total,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [drhm_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int FW = drhm_pkg::FRAC_W;

  logic            enable_r, enable_nxt;
  logic [FW-1:0]   deg_frac_r, deg_frac_nxt;
  logic [FW-1:0]   err_frac_r, err_frac_nxt;
  logic [FW-1:0]   thr_deg;
  logic [FW-1:0]   thr_err_raw;
  logic [FW-1:0]   thr_err;
  logic [1:0]      reg_idx;
  logic            wr_en;

  logic            q_full;
  logic            push;
  drhm_pkg::item_t push_item;
  logic            pop;
  logic            q_valid;
  drhm_pkg::item_t q_item;

  always_comb begin
    pready       = 1'b1;
    reg_idx      = paddr[3:2];
    wr_en        = psel && penable && pwrite;
    enable_nxt   = enable_r;
    deg_frac_nxt = deg_frac_r;
    err_frac_nxt = err_frac_r;
    prdata       = '0;
    unique case (drhm_pkg::reg_idx_t'(reg_idx))
      drhm_pkg::REG_ENABLE: begin
        prdata = {31'b0, enable_r};
        if (wr_en) begin
          enable_nxt = pwdata[0];
        end
      end
      drhm_pkg::REG_DEG_FRAC: begin
        prdata = {{(32 - FW){1'b0}}, deg_frac_r};
        if (wr_en) begin
          deg_frac_nxt = pwdata[FW-1:0];
        end
      end
      drhm_pkg::REG_ERR_FRAC: begin
        prdata = {{(32 - FW){1'b0}}, err_frac_r};
        if (wr_en) begin
          err_frac_nxt = pwdata[FW-1:0];
        end
      end
      default: prdata = '0;
    endcase

    thr_deg     = drhm_pkg::clamp_frac(deg_frac_r);
    thr_err_raw = drhm_pkg::clamp_frac(err_frac_r);
    thr_err     = (thr_err_raw < thr_deg) ? thr_deg : thr_err_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b1;
      deg_frac_r <= drhm_pkg::DEG_FRAC_RST;
      err_frac_r <= drhm_pkg::ERR_FRAC_RST;
    end else begin
      enable_r   <= enable_nxt;
      deg_frac_r <= deg_frac_nxt;
      err_frac_r <= err_frac_nxt;
    end
  end

  drhm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_count (in_count),
    .in_stall (in_stall),
    .enable   (enable_r),
    .q_full   (q_full),
    .push     (push),
    .item     (push_item)
  );

  drhm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  drhm_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .pop                 (pop),
    .thr_deg             (thr_deg),
    .thr_err             (thr_err),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_health          (out_health),
    .out_processed_total (out_processed_total),
    .out_dropped_total   (out_dropped_total),
    .out_signal_total    (out_signal_total),
    .out_error_total     (out_error_total)
  );

endmodule

// File: bench/tb_drop_rate_health_monitor.sv
// Self-checking testbench for drop_rate_health_monitor: event items, APB writes,
// a transaction-level predictor of counters and health, and a scoreboard of results.
// Depends on drhm_pkg and the monitor RTL only.
`timescale 1ns / 1ps

module tb_drop_rate_health_monitor;

  localparam int          LIMIT       = 100000;
  localparam int          SETTLE      = 8;
  localparam logic [2:0]  KIND_UNUSED = 3'd7;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam logic [63:0] MAX64       = '1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] count;
  } event_item_t;

  typedef struct packed {
    drhm_pkg::health_t health;
    logic [63:0]       processed;
    logic [63:0]       dropped;
    logic [63:0]       signals;
    logic [63:0]       errors;
  } health_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = '0;
  logic [63:0] in_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_health;
  logic [63:0] out_processed_total;
  logic [63:0] out_dropped_total;
  logic [63:0] out_signal_total;
  logic [63:0] out_error_total;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [drhm_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  drop_rate_health_monitor uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind), .in_count(in_count),
    .out_valid(out_valid), .out_stall(out_stall), .out_health(out_health),
    .out_processed_total(out_processed_total), .out_dropped_total(out_dropped_total),
    .out_signal_total(out_signal_total), .out_error_total(out_error_total),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  event_item_t    event_backlog[$];
  health_report_t reports_due[$];
  health_report_t due;
  event_item_t    next_item;
  bit             drv_busy = 1'b0;
  int unsigned    tx_idle_pct = 0;
  int unsigned    rx_idle_pct = 0;
  int unsigned    cycles = 0;
  int unsigned    fails = 0;
  int unsigned    n_items = 0;
  int unsigned    n_writes = 0;
  int unsigned    n_checks = 0;

  logic              en_q = 1'b1;
  logic [16:0]       deg_q = drhm_pkg::DEG_FRAC_RST;
  logic [16:0]       err_q = drhm_pkg::ERR_FRAC_RST;
  logic [63:0]       proc_q = '0;
  logic [63:0]       drop_q = '0;
  logic [63:0]       sig_q = '0;
  logic [63:0]       errs_q = '0;
  drhm_pkg::health_t health_q = drhm_pkg::HEALTH_OK;
  int unsigned       phase_q = 0;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? MAX64 : s[63:0];
  endfunction

  function automatic bit ratio_reaches(input logic [16:0] t);
    logic [95:0] lhs, rhs;
    lhs = {16'b0, drop_q, 16'b0};
    rhs = 96'(t) * 96'(proc_q);
    if (proc_q == '0) return t == '0;
    return lhs >= rhs;
  endfunction

  function automatic health_report_t advance_counters(input logic [2:0] kind,
                                                      input logic [63:0] count);
    health_report_t r;
    logic [16:0] d, e;
    case (kind)
      drhm_pkg::KIND_PROCESSED: begin
        if (en_q && count != '0) proc_q = sat_add(proc_q, count);
      end
      drhm_pkg::KIND_DROPPED: begin
        if (en_q && count != '0) begin
          drop_q = sat_add(drop_q, count);
          phase_q++;
          if (phase_q >= drhm_pkg::CHECK_PERIOD) begin
            phase_q = 0;
            n_checks++;
            d = (deg_q > drhm_pkg::FRACTION_ONE) ? drhm_pkg::FRACTION_ONE : deg_q;
            e = (err_q > drhm_pkg::FRACTION_ONE) ? drhm_pkg::FRACTION_ONE : err_q;
            if (e < d) e = d;
            if (ratio_reaches(e)) health_q = drhm_pkg::HEALTH_ERROR;
            else if (ratio_reaches(d)) health_q = drhm_pkg::HEALTH_DEGRADED;
            else health_q = drhm_pkg::HEALTH_OK;
          end
        end
      end
      drhm_pkg::KIND_SIGNAL: begin
        if (en_q) sig_q = sat_add(sig_q, 64'd1);
      end
      drhm_pkg::KIND_ERROR: begin
        errs_q = sat_add(errs_q, 64'd1);
        health_q = drhm_pkg::HEALTH_ERROR;
      end
      drhm_pkg::KIND_DEGRADED: health_q = drhm_pkg::HEALTH_DEGRADED;
      drhm_pkg::KIND_HEALTHY: begin
        errs_q = '0;
        health_q = drhm_pkg::HEALTH_OK;
      end
      drhm_pkg::KIND_CLEAR: begin
        proc_q = '0;
        drop_q = '0;
        sig_q = '0;
        errs_q = '0;
        health_q = drhm_pkg::HEALTH_OK;
      end
      default: ;
    endcase
    r.health = health_q;
    r.processed = proc_q;
    r.dropped = drop_q;
    r.signals = sig_q;
    r.errors = errs_q;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("cycle %0d: %s: got %0h, expected %0h", cycles, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("cycle limit reached with %0d results outstanding", reports_due.size());
      $display("** drop_rate_health_monitor: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!drv_busy) begin
      if (rst_n && event_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        next_item = event_backlog.pop_front();
        in_kind  <= next_item.kind;
        in_count <= next_item.count;
        in_valid <= 1'b1;
        drv_busy = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        flag_mismatch("result with nothing outstanding", out_processed_total, '0);
      end else begin
        due = reports_due.pop_front();
        if (out_health != due.health)
          flag_mismatch("health", 64'(out_health), 64'(due.health));
        if (out_processed_total != due.processed)
          flag_mismatch("processed_total", out_processed_total, due.processed);
        if (out_dropped_total != due.dropped)
          flag_mismatch("dropped_total", out_dropped_total, due.dropped);
        if (out_signal_total != due.signals)
          flag_mismatch("signal_total", out_signal_total, due.signals);
        if (out_error_total != due.errors)
          flag_mismatch("error_total", out_error_total, due.errors);
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      drv_busy = 1'b0;
      n_items++;
      reports_due.push_back(advance_counters(in_kind, in_count));
    end
  end

  task automatic queue_event(input logic [2:0] kind, input logic [63:0] count);
    event_item_t it;
    it.kind = kind;
    it.count = count;
    event_backlog.push_back(it);
  endtask

  task automatic settle();
    while (event_backlog.size() != 0 || drv_busy || reports_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= drhm_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_writes++;
    case (idx)
      drhm_pkg::REG_ENABLE:   en_q = data[0];
      drhm_pkg::REG_DEG_FRAC: deg_q = data[16:0];
      drhm_pkg::REG_ERR_FRAC: err_q = data[16:0];
      default: ;
    endcase
  endtask

  function automatic event_item_t random_event(input int unsigned dmax,
                                               input int unsigned pmax);
    event_item_t it;
    int unsigned pick, shape;
    pick = $urandom_range(99);
    shape = $urandom_range(199);
    if (pick < 75) it.kind = drhm_pkg::KIND_DROPPED;
    else if (pick < 90) it.kind = drhm_pkg::KIND_PROCESSED;
    else if (pick < 93) it.kind = drhm_pkg::KIND_SIGNAL;
    else if (pick < 95) it.kind = drhm_pkg::KIND_ERROR;
    else if (pick < 96) it.kind = drhm_pkg::KIND_DEGRADED;
    else if (pick < 97) it.kind = drhm_pkg::KIND_HEALTHY;
    else if (pick < 98) it.kind = drhm_pkg::KIND_CLEAR;
    else it.kind = KIND_UNUSED;
    if (it.kind != drhm_pkg::KIND_PROCESSED && it.kind != drhm_pkg::KIND_DROPPED)
      it.count = {$urandom, $urandom};
    else if (shape < 4)
      it.count = '0;
    else if (shape == 4)
      it.count = {$urandom, $urandom};
    else if (shape == 5)
      it.count = MAX64 - 64'($urandom_range(255));
    else
      it.count = 64'($urandom_range(it.kind == drhm_pkg::KIND_DROPPED ? dmax : pmax, 1));
    return it;
  endfunction

  // Random traffic of at most n_max items after a clear, cut short once a full
  // drop-check period has been queued.
  task automatic queue_random(input int unsigned dmax, input int unsigned pmax,
                              input int unsigned n_max);
    event_item_t it;
    int unsigned drops, n;
    drops = 0;
    n = 0;
    queue_event(drhm_pkg::KIND_CLEAR, {$urandom, $urandom});
    while (drops < drhm_pkg::CHECK_PERIOD && n < n_max) begin
      it = random_event(dmax, pmax);
      queue_event(it.kind, it.count);
      if (it.kind == drhm_pkg::KIND_DROPPED && it.count != '0) drops++;
      n++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 23;
    rx_idle_pct = 83;
    write_reg(drhm_pkg::REG_ENABLE, 32'd1);
    write_reg(drhm_pkg::REG_DEG_FRAC, 32'(drhm_pkg::DEG_FRAC_RST));
    write_reg(drhm_pkg::REG_ERR_FRAC, 32'(drhm_pkg::ERR_FRAC_RST));

    queue_event(drhm_pkg::KIND_PROCESSED, '0);
    queue_event(drhm_pkg::KIND_DROPPED, '0);
    queue_event(drhm_pkg::KIND_PROCESSED, MAX64);
    queue_event(drhm_pkg::KIND_PROCESSED, 64'd1);
    queue_event(drhm_pkg::KIND_DROPPED, 64'd1);
    queue_event(drhm_pkg::KIND_DROPPED, MAX64);
    queue_event(drhm_pkg::KIND_SIGNAL, MAX64);
    queue_event(drhm_pkg::KIND_ERROR, '0);
    queue_event(drhm_pkg::KIND_ERROR, MAX64);
    queue_event(drhm_pkg::KIND_DEGRADED, '0);
    queue_event(drhm_pkg::KIND_HEALTHY, '0);
    queue_event(KIND_UNUSED, MAX64);
    queue_event(drhm_pkg::KIND_CLEAR, '0);
    queue_event(drhm_pkg::KIND_SIGNAL, {$urandom, $urandom});
    queue_event(drhm_pkg::KIND_PROCESSED, 64'h8000_0000_0000_0000);
    queue_event(drhm_pkg::KIND_PROCESSED, 64'h7FFF_FFFF_FFFF_FFFF);
    queue_event(drhm_pkg::KIND_PROCESSED, 64'd1);
    queue_event(drhm_pkg::KIND_ERROR, '0);
    queue_event(drhm_pkg::KIND_CLEAR, MAX64);
    queue_event(drhm_pkg::KIND_HEALTHY, MAX64);
    settle();

    write_reg(drhm_pkg::REG_ENABLE, 32'd0);
    queue_event(drhm_pkg::KIND_PROCESSED, 64'd5);
    queue_event(drhm_pkg::KIND_DROPPED, 64'd5);
    queue_event(drhm_pkg::KIND_SIGNAL, '0);
    queue_event(drhm_pkg::KIND_ERROR, '0);
    queue_event(drhm_pkg::KIND_DEGRADED, '0);
    queue_event(drhm_pkg::KIND_HEALTHY, '0);
    queue_event(drhm_pkg::KIND_CLEAR, '0);
    queue_event(drhm_pkg::KIND_DROPPED, '0);
    settle();
    write_reg(drhm_pkg::REG_ENABLE, 32'd1);

    queue_random(1, 1000, 120);
    settle();
    queue_random(30, 1000, 80);
    settle();

    tx_idle_pct = 83;
    rx_idle_pct = 23;
    write_reg(drhm_pkg::REG_DEG_FRAC, 32'd0);
    queue_random(100, 1000, 60);
    settle();
    write_reg(drhm_pkg::REG_ERR_FRAC, 32'd65536);
    queue_random(100, 1000, 40);
    settle();
    write_reg(drhm_pkg::REG_DEG_FRAC, 32'd65536);
    write_reg(drhm_pkg::REG_ERR_FRAC, 32'd0);
    queue_random(2000, 100, 60);
    settle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(drhm_pkg::REG_DEG_FRAC, 32'hABCD_FFFF);
    write_reg(drhm_pkg::REG_ERR_FRAC, 32'h5A5B_FFFF);
    queue_random(1000, 100, 80);
    settle();
    write_reg(drhm_pkg::REG_DEG_FRAC, 32'd20000);
    write_reg(drhm_pkg::REG_ERR_FRAC, 32'd10000);
    queue_random(9, 100, 60);
    settle();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(drhm_pkg::REG_ENABLE, 32'hFFFF_FFFE);
    queue_random(100, 100, 40);
    settle();
    write_reg(drhm_pkg::REG_ENABLE, 32'd1);
    write_reg(drhm_pkg::REG_DEG_FRAC, 32'(drhm_pkg::DEG_FRAC_RST));
    write_reg(drhm_pkg::REG_ERR_FRAC, 32'(drhm_pkg::ERR_FRAC_RST));
    queue_random(30, 1000, 40);
    settle();

    $display("Drove %0d event items across %0d register writes and three idle regimes,",
             n_items, n_writes);
    $display("with %0d drop-ratio checks predicted and %0d mismatches.", n_checks, fails);
    if (fails == 0) begin
      $display("** drop_rate_health_monitor: PASSED **");
    end else begin
      $display("** drop_rate_health_monitor: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/drhm_pkg.sv
hdl/drhm_front.sv
hdl/drhm_queue.sv
hdl/drhm_back.sv
hdl/drop_rate_health_monitor.sv
bench/tb_drop_rate_health_monitor.sv
